// ===== rtl/tdpt_pkg.sv =====
// Shared types and constants for the trial-division prime tester.
// Holds the payload structs and the controller/datapath command and status groups.
// No dependencies.
`default_nettype none

package tdpt_pkg;

  // Width of a tested value; divisor and remainder widths follow from it
  localparam int VALUE_BITS = 32;
  localparam int DIV_BITS   = VALUE_BITS / 2 + 1;
  localparam int REM_BITS   = DIV_BITS + 1;
  localparam int CNT_BITS   = $clog2(VALUE_BITS);

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic                         last_element;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] tested_value;
    logic                         is_prime;
    logic                         end_of_matrix;
  } out_item_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;         // latch a new item, reset divisor to two
    logic div_start;    // clear remainder, start at the top bit
    logic div_step;     // one restoring remainder step
    logic advance;      // move to the next divisor
    logic verdict_set;  // write verdict register
    logic verdict_val;
    logic publish;      // move result into the output register
  } tdpt_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic below_two;  // negative, zero or one
    logic sq_gt_n;    // divisor squared exceeds the value
    logic div_last;   // current remainder step is the last one
    logic rem_zero;   // remainder is zero
    logic out_busy;   // output register holds a result not taken this cycle
  } tdpt_status_t;

endpackage

`default_nettype wire

// ===== rtl/trial_division_prime_test.sv =====
// Top level of the trial-division prime tester: joins controller and datapath.
// Depends on tdpt_pkg, tdpt_ctrl and tdpt_datapath.
//
//   channel | signals                       | carries
//   --------+-------------------------------+------------------------------------
//   in      | in_valid, in_ready, in_data   | value, last_element
//   out     | out_valid, out_ready, out_data| tested_value, is_prime, end_of_matrix
//
// One item at a time. Each trial divisor passes through a bound check, a bit-serial
// remainder over every value bit and a test; a prime n is tried against every divisor
// from two up to floor(sqrt(n)) before the bound check declares it prime.
// Negative values, zero and one go from the bound check straight to the result.
// Synchronous reset clears the state machine and output valid only.
// A result waiting in the output register does not block the next transfer in;
// the controller holds its finished verdict until that register frees.
`default_nettype none

module trial_division_prime_test (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire tdpt_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output tdpt_pkg::out_item_t      out_data
);
  import tdpt_pkg::*;

  tdpt_cmd_t    cmd;
  tdpt_status_t status;

  tdpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tdpt_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/tdpt_datapath.sv =====
// Datapath of the trial-division prime tester: value, divisor, running square,
// bit-serial remainder unit, verdict and output register. Uses tdpt_pkg.
`default_nettype none

module tdpt_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tdpt_pkg::in_item_t in_data,
  input  wire tdpt_pkg::tdpt_cmd_t cmd,
  output tdpt_pkg::tdpt_status_t  status,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output tdpt_pkg::out_item_t     out_data
);
  import tdpt_pkg::*;

  logic [VALUE_BITS-1:0] n;
  logic                  last;
  logic [DIV_BITS-1:0]   d;
  logic [VALUE_BITS-1:0] sq;
  logic [REM_BITS-1:0]   rem;
  logic [CNT_BITS-1:0]   cnt;
  logic                  verdict;

  logic [REM_BITS-1:0]   rem_shift;
  logic [REM_BITS-1:0]   d_ext;
  logic [VALUE_BITS-1:0] sq_inc;

  // Shift in the next dividend bit; subtract when it fits
  assign rem_shift = {rem[REM_BITS-2:0], n[cnt]};
  assign d_ext     = REM_BITS'(d);
  // (d+1)^2 = d^2 + 2d + 1
  assign sq_inc    = VALUE_BITS'({d, 1'b1});

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n    <= in_data.value;
      last <= in_data.last_element;
      d    <= DIV_BITS'(2);
      sq   <= VALUE_BITS'(4);
    end else if (cmd.advance) begin
      d    <= d + DIV_BITS'(1);
      sq   <= sq + sq_inc;
    end
    if (cmd.div_start) begin
      rem <= '0;
      cnt <= CNT_BITS'(VALUE_BITS - 1);
    end else if (cmd.div_step) begin
      rem <= (rem_shift >= d_ext) ? rem_shift - d_ext : rem_shift;
      cnt <= cnt - CNT_BITS'(1);
    end
    if (cmd.verdict_set) begin
      verdict <= cmd.verdict_val;
    end
    if (cmd.publish) begin
      out_data.tested_value  <= n;
      out_data.is_prime      <= verdict;
      out_data.end_of_matrix <= last;
    end
  end

  // Output valid: set on publish, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    status.below_two = n[VALUE_BITS-1] | (n[VALUE_BITS-2:1] == '0);
    status.sq_gt_n   = sq > n;
    status.div_last  = cnt == '0;
    status.rem_zero  = rem == '0;
    status.out_busy  = out_valid & ~out_ready;
  end

endmodule

`default_nettype wire

// ===== rtl/tdpt_ctrl.sv =====
// Controller of the trial-division prime tester: one-hot state machine that
// sequences load, bound check, remainder steps and result hand-off. Uses tdpt_pkg.
`default_nettype none

module tdpt_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire tdpt_pkg::tdpt_status_t status,
  output tdpt_pkg::tdpt_cmd_t        cmd
);
  import tdpt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_BOUND = 5'b00010,
    S_DIV   = 5'b00100,
    S_TEST  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_BOUND;
        end
      end
      S_BOUND: begin
        if (status.below_two) begin
          cmd.verdict_set = 1'b1;
          cmd.verdict_val = 1'b0;
          state_next      = S_DONE;
        end else if (status.sq_gt_n) begin
          cmd.verdict_set = 1'b1;
          cmd.verdict_val = 1'b1;
          state_next      = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_TEST;
        end
      end
      S_TEST: begin
        if (status.rem_zero) begin
          cmd.verdict_set = 1'b1;
          cmd.verdict_val = 1'b0;
          state_next      = S_DONE;
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_BOUND;
        end
      end
      S_DONE: begin
        if (!status.out_busy) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire
